### rtl/core/lobm_pkg.sv
package lobm_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;

   localparam logic [1:0] TIF_GTC = 2'd0;
   localparam logic [1:0] TIF_IOC = 2'd1;
   localparam logic [1:0] TIF_FOK = 2'd2;

   localparam int ID_BITS      = 31;
   localparam int TOP_QTY_BITS = 24;
   localparam int ARR_BITS     = 32;

   // Verdict of the scan unit, handed back to the sequencer.
   typedef struct packed {
      logic better;
   } scan_res_type;

endpackage

### rtl/core/lobm_scan.sv
module lobm_scan import lobm_pkg::*; #(
   parameter int PRICE_BITS = 16
) (
   input  logic                  cand_side,
   input  logic [PRICE_BITS-1:0] cand_price,
   input  logic [ARR_BITS-1:0]   cand_age,
   input  logic                  have_best,
   input  logic [PRICE_BITS-1:0] best_price,
   input  logic [ARR_BITS-1:0]   best_age,
   output scan_res_type          res
);

   // Shared compare: is the candidate slot ahead of the best so far in
   // price-time priority for its own side.
   always_comb begin
      if (!have_best) begin
         res.better = 1'b1;
      end else if (cand_price != best_price) begin
         res.better = cand_side ? (cand_price < best_price) : (cand_price > best_price);
      end else begin
         res.better = cand_age > best_age;
      end
   end

endmodule

### rtl/core/limit_order_book_matcher.sv
// Price-time priority limit order book over MAX_ORDERS slots held in
// registers. Each request (add, cancel or modify) yields zero or more trade
// responses with rsp_tlast low, then one status response with rsp_tlast high
// that carries the accepted flag and the top of book. The block serves one
// request at a time; one shared compare unit visits one slot per cycle. A
// request makes, at most, one pass over the store to find an id or sum the
// fill-or-kill volume, one best-order search per trade and one more that ends
// the match, then a rest pass and two top-of-book passes (search then sum) per
// side. Each response waits in the output register until taken, which holds up
// the request.
module limit_order_book_matcher import lobm_pkg::*; #(
   parameter int MAX_ORDERS = 32,
   parameter int PRICE_BITS = 16,
   parameter int QTY_BITS   = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // fields from bit 0: opcode 2, order_id 31, side 1, order_kind 1,
   // time_in_force 2, price_ticks PRICE_BITS, quantity QTY_BITS, timestamp 32
   input  logic [((69+PRICE_BITS+QTY_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // fields from bit 0: trade_price 16, trade_qty 20, buyer_id 31,
   // seller_id 31, accepted 1, bid_valid 1, best_bid_price 16,
   // best_bid_qty 24, ask_valid 1, best_ask_price 16, best_ask_qty 24
   output logic [183:0] rsp_tdata,
   output logic rsp_tlast
);

   localparam int SB = $clog2(MAX_ORDERS);
   localparam int SUMB = QTY_BITS + SB + 1;
   localparam int P0 = 37;
   localparam int Q0 = 37 + PRICE_BITS;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_FIND  = 11'b00000000010,
      ST_FOK   = 11'b00000000100,
      ST_BEST  = 11'b00000001000,
      ST_TRADE = 11'b00000010000,
      ST_WTRD  = 11'b00000100000,
      ST_REST  = 11'b00001000000,
      ST_TOPB  = 11'b00010000000,
      ST_TOPS  = 11'b00100000000,
      ST_FINAL = 11'b01000000000,
      ST_WFIN  = 11'b10000000000
   } state_type;

   state_type state_ff;

   logic [MAX_ORDERS-1:0] valid_ff;
   logic [ID_BITS-1:0]    sid_ff  [MAX_ORDERS];
   logic                  sside_ff[MAX_ORDERS];
   logic [PRICE_BITS-1:0] spx_ff  [MAX_ORDERS];
   logic [QTY_BITS-1:0]   srem_ff [MAX_ORDERS];
   logic [ARR_BITS-1:0]   sarr_ff [MAX_ORDERS];
   logic [ARR_BITS-1:0]   arr_ff;
   logic [ID_BITS-1:0]    auto_ff;

   // request context
   logic [1:0]            op_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic                  side_ff, mkt_ff;
   logic [1:0]            tif_ff;
   logic [PRICE_BITS-1:0] px_ff;
   logic [QTY_BITS-1:0]   qty_ff;
   logic                  acc_ff;

   // scan bookkeeping
   logic [SB-1:0]         idx_ff;
   logic                  pass2_ff;  // top of book: sum pass after search
   logic                  have_ff;
   logic [SB-1:0]         bidx_ff;
   logic [PRICE_BITS-1:0] bpx_ff;
   logic [ARR_BITS-1:0]   bage_ff;
   logic [SUMB-1:0]       sum_ff;
   logic                  bv_ff, av_ff;
   logic [15:0]           bp_ff, ap_ff;
   logic [TOP_QTY_BITS-1:0] bq_ff, aq_ff;

   logic                  ov_ff, olast_ff;
   logic [183:0]          odata_ff;

   logic                  last_slot;
   logic [SB-1:0]         idx_next;
   logic [ARR_BITS-1:0]   cage;
   logic                  opp, cross_px, scan_side;
   scan_res_type          sres;
   logic [QTY_BITS-1:0]   tq;

   assign last_slot = (idx_ff == SB'(MAX_ORDERS-1));
   // The slot index returns to zero after the last slot, whatever the depth.
   assign idx_next  = last_slot ? '0 : idx_ff + SB'(1);
   assign cage      = arr_ff - sarr_ff[idx_ff];
   assign opp       = ~side_ff;
   assign scan_side = (state_ff == ST_TOPB) ? 1'b0 : (state_ff == ST_TOPS) ? 1'b1 : opp;
   assign tq        = (qty_ff < srem_ff[bidx_ff]) ? qty_ff : srem_ff[bidx_ff];

   lobm_scan #(.PRICE_BITS(PRICE_BITS)) u_scan (
      .cand_side (scan_side),
      .cand_price(spx_ff[idx_ff]),
      .cand_age  (cage),
      .have_best (have_ff),
      .best_price(bpx_ff),
      .best_age  (bage_ff),
      .res       (sres)
   );

   function automatic logic crosses(input logic buy, input logic mkt,
                                    input logic [PRICE_BITS-1:0] lim,
                                    input logic [PRICE_BITS-1:0] px);
      crosses = mkt | (buy ? (px <= lim) : (px >= lim));
   endfunction

   assign cross_px = crosses(~side_ff, mkt_ff, px_ff, spx_ff[idx_ff]);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         arr_ff   <= '0;
         auto_ff  <= ID_BITS'(1);
         ov_ff    <= 1'b0;
         olast_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  op_ff   <= req_tdata[1:0];
                  side_ff <= req_tdata[33];
                  mkt_ff  <= req_tdata[34];
                  tif_ff  <= req_tdata[36:35];
                  px_ff   <= req_tdata[P0 +: PRICE_BITS];
                  qty_ff  <= req_tdata[Q0 +: QTY_BITS];
                  acc_ff  <= (req_tdata[1:0] == OP_ADD);
                  idx_ff  <= '0;
                  have_ff <= 1'b0;
                  sum_ff  <= '0;
                  pass2_ff <= 1'b0;
                  // an add with id zero takes the next automatic id
                  id_ff   <= (req_tdata[1:0] == OP_ADD && req_tdata[32:2] == '0) ?
                             auto_ff : req_tdata[32:2];
                  if (req_tdata[1:0] == OP_ADD) begin
                     if (req_tdata[32:2] == '0) begin
                        auto_ff <= (auto_ff == '1) ? ID_BITS'(1) : auto_ff + ID_BITS'(1);
                     end
                     state_ff <= (req_tdata[36:35] == TIF_FOK) ? ST_FOK : ST_BEST;
                  end else if (req_tdata[1:0] == OP_CANCEL || req_tdata[1:0] == OP_MODIFY) begin
                     state_ff <= ST_FIND;
                  end else begin
                     state_ff <= ST_TOPB;
                  end
               end
            end
            ST_FIND: begin
               // most recent arrival carrying the id: smallest age
               logic          hit;
               logic [SB-1:0] f;
               hit = valid_ff[idx_ff] && sid_ff[idx_ff] == id_ff &&
                     (!have_ff || cage < bage_ff);
               f = hit ? idx_ff : bidx_ff;
               idx_ff <= idx_next;
               if (!last_slot) begin
                  if (hit) begin
                     have_ff <= 1'b1;
                     bidx_ff <= idx_ff;
                     bage_ff <= cage;
                  end
               end else begin
                  have_ff <= 1'b0;
                  if (have_ff || hit) begin
                     valid_ff[f] <= 1'b0;
                     acc_ff <= 1'b1;
                     if (op_ff == OP_MODIFY && qty_ff != '0) begin
                        side_ff  <= sside_ff[f];
                        mkt_ff   <= 1'b0;
                        tif_ff   <= TIF_GTC;
                        state_ff <= ST_BEST;
                     end else begin
                        state_ff <= ST_TOPB;
                     end
                  end else begin
                     state_ff <= ST_TOPB;
                  end
               end
            end
            ST_FOK: begin
               logic [SUMB-1:0] s;
               s = sum_ff;
               if (valid_ff[idx_ff] && sside_ff[idx_ff] == opp && cross_px)
                  s = sum_ff + SUMB'(srem_ff[idx_ff]);
               sum_ff <= s;
               idx_ff <= idx_next;
               if (last_slot)
                  state_ff <= (s < SUMB'(qty_ff)) ? ST_TOPB : ST_BEST;
            end
            ST_BEST: begin
               if (qty_ff == '0) begin
                  state_ff <= ST_REST;
                  idx_ff <= '0;
               end else begin
                  if (valid_ff[idx_ff] && sside_ff[idx_ff] == opp && sres.better) begin
                     have_ff <= 1'b1;
                     bidx_ff <= idx_ff;
                     bpx_ff  <= spx_ff[idx_ff];
                     bage_ff <= cage;
                  end
                  idx_ff <= idx_next;
                  if (last_slot) state_ff <= ST_TRADE;
               end
            end
            ST_TRADE: begin
               idx_ff <= '0;
               have_ff <= 1'b0;
               if (have_ff && crosses(~side_ff, mkt_ff, px_ff, bpx_ff)) begin
                  odata_ff <= {86'd0,
                               side_ff ? id_ff : sid_ff[bidx_ff],
                               side_ff ? sid_ff[bidx_ff] : id_ff,
                               20'(tq), 16'(spx_ff[bidx_ff])};
                  ov_ff    <= 1'b1;
                  olast_ff <= 1'b0;
                  qty_ff   <= qty_ff - tq;
                  srem_ff[bidx_ff] <= srem_ff[bidx_ff] - tq;
                  if (srem_ff[bidx_ff] == tq) valid_ff[bidx_ff] <= 1'b0;
                  state_ff <= ST_WTRD;
               end else begin
                  state_ff <= ST_REST;
               end
            end
            ST_WTRD: begin
               if (rsp_tready) begin
                  ov_ff <= 1'b0;
                  state_ff <= ST_BEST;
               end
            end
            ST_REST: begin
               // first free slot takes the remainder
               if (mkt_ff || qty_ff == '0 || tif_ff == TIF_IOC || tif_ff == TIF_FOK) begin
                  state_ff <= ST_TOPB;
                  idx_ff <= '0;
               end else if (!valid_ff[idx_ff]) begin
                  valid_ff[idx_ff] <= 1'b1;
                  sid_ff[idx_ff]   <= id_ff;
                  sside_ff[idx_ff] <= side_ff;
                  spx_ff[idx_ff]   <= px_ff;
                  srem_ff[idx_ff]  <= qty_ff;
                  sarr_ff[idx_ff]  <= arr_ff;
                  arr_ff   <= arr_ff + ARR_BITS'(1);
                  idx_ff   <= '0;
                  state_ff <= ST_TOPB;
               end else begin
                  idx_ff <= idx_next;
                  if (last_slot) begin
                     acc_ff <= 1'b0;
                     state_ff <= ST_TOPB;
                  end
               end
            end
            ST_TOPB, ST_TOPS: begin
               logic mine;
               logic [SUMB-1:0] s;
               mine = valid_ff[idx_ff] && sside_ff[idx_ff] == scan_side;
               s = sum_ff;
               if (!pass2_ff) begin
                  if (mine && sres.better) begin
                     have_ff <= 1'b1;
                     bpx_ff  <= spx_ff[idx_ff];
                     bage_ff <= cage;
                  end
               end else if (mine && spx_ff[idx_ff] == bpx_ff) begin
                  s = sum_ff + SUMB'(srem_ff[idx_ff]);
               end
               idx_ff <= idx_next;
               if (!last_slot) begin
                  sum_ff <= s;
               end else if (!pass2_ff) begin
                  pass2_ff <= 1'b1;
                  sum_ff <= '0;
               end else begin
                  logic [TOP_QTY_BITS-1:0] q;
                  q = (s > SUMB'({TOP_QTY_BITS{1'b1}})) ? '1 : TOP_QTY_BITS'(s);
                  pass2_ff <= 1'b0;
                  have_ff  <= 1'b0;
                  sum_ff   <= '0;
                  if (state_ff == ST_TOPB) begin
                     bv_ff <= have_ff;
                     bp_ff <= have_ff ? 16'(bpx_ff) : 16'd0;
                     bq_ff <= have_ff ? q : '0;
                     state_ff <= ST_TOPS;
                  end else begin
                     av_ff <= have_ff;
                     ap_ff <= have_ff ? 16'(bpx_ff) : 16'd0;
                     aq_ff <= have_ff ? q : '0;
                     state_ff <= ST_FINAL;
                  end
               end
            end
            ST_FINAL: begin
               odata_ff <= {3'd0, aq_ff, ap_ff, av_ff,
                            bq_ff, bp_ff, bv_ff, acc_ff, 98'd0};
               ov_ff    <= 1'b1;
               olast_ff <= 1'b1;
               state_ff <= ST_WFIN;
            end
            ST_WFIN: begin
               if (rsp_tready) begin
                  ov_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/lobm_checker.sv
module lobm_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast,
   input logic [183:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_busy_no_out: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("response pending while ready for a request");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready again straight after a request");

   a_trade_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[183:98] == '0)
      else $error("status fields set on a trade response");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tlast(rsp_tlast),
   .rsp_tdata(rsp_tdata)
);
